// File: hw/rtl/vat_pkg.sv
// Shared types and constants for the vertex affine transform pipeline.
// No dependencies; every other RTL file of the block imports this package.
`default_nettype none

package vat_pkg;

  // Datapath widths.
  localparam int COORD_W    = 32;
  localparam int AMOUNT_W   = 32;
  localparam int TRIG_W     = 18;
  localparam int PROD_W     = 64;
  localparam int ACC_W      = 66;
  localparam int LIN_W      = 33;
  localparam int FRAC_BITS  = 16;
  localparam int NUM_STAGES = 4;
  localparam int MODE_W     = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Register values after reset.
  localparam logic signed [TRIG_W-1:0]   COS_RESET    = 18'sd65536;
  localparam logic signed [TRIG_W-1:0]   SIN_RESET    = 18'sd0;
  localparam logic signed [AMOUNT_W-1:0] AMOUNT_RESET = 32'sd0;

  // Operation codes held in the mode register. Code 7 passes vertices through.
  typedef enum logic [MODE_W-1:0] {
    MODE_SCALE  = 3'd0,
    MODE_MOVE_X = 3'd1,
    MODE_MOVE_Y = 3'd2,
    MODE_MOVE_Z = 3'd3,
    MODE_ROT_X  = 3'd4,
    MODE_ROT_Y  = 3'd5,
    MODE_ROT_Z  = 3'd6
  } mode_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE   = 3'd0,
    REG_AMOUNT = 3'd1,
    REG_COS    = 3'd2,
    REG_SIN    = 3'd3
  } reg_idx_t;

  // What one coordinate lane does with its operands.
  typedef enum logic [1:0] {
    LANE_PASS = 2'd0,
    LANE_ADD  = 2'd1,
    LANE_MAC  = 2'd2
  } lane_kind_t;

  // Operands of one lane: result = coord_a*fac_a +/- coord_b*fac_b,
  // or coord_a + fac_a, or coord_a.
  typedef struct packed {
    lane_kind_t                  kind;
    logic signed [COORD_W-1:0]   coord_a;
    logic signed [AMOUNT_W-1:0]  fac_a;
    logic signed [COORD_W-1:0]   coord_b;
    logic signed [AMOUNT_W-1:0]  fac_b;
    logic                        neg_b;
  } lane_op_t;

  // Per-stage load enables from the flow control to the datapath.
  typedef struct packed {
    logic [NUM_STAGES-1:0] load;
  } pipe_ctrl_t;

endpackage

`default_nettype wire

// File: hw/rtl/vat_operand_sel.sv
// First pipeline stage: decodes the mode and registers the multiplier operands per lane.
// Depends on vat_pkg.
`default_nettype none

module vat_operand_sel (
  input  wire logic                               clk,
  input  wire logic                               load,
  input  wire vat_pkg::mode_t                     mode,
  input  wire logic signed [vat_pkg::AMOUNT_W-1:0] amount,
  input  wire logic signed [vat_pkg::TRIG_W-1:0]   cos_val,
  input  wire logic signed [vat_pkg::TRIG_W-1:0]   sin_val,
  input  wire logic signed [vat_pkg::COORD_W-1:0]  coord_x,
  input  wire logic signed [vat_pkg::COORD_W-1:0]  coord_y,
  input  wire logic signed [vat_pkg::COORD_W-1:0]  coord_z,
  output vat_pkg::lane_op_t                       op_x_r,
  output vat_pkg::lane_op_t                       op_y_r,
  output vat_pkg::lane_op_t                       op_z_r
);
  import vat_pkg::*;

  logic signed [AMOUNT_W-1:0] cos_ext;
  logic signed [AMOUNT_W-1:0] sin_ext;
  lane_op_t                   op_x_nxt;
  lane_op_t                   op_y_nxt;
  lane_op_t                   op_z_nxt;

  function automatic lane_op_t make_op(
    input lane_kind_t                 kind,
    input logic signed [COORD_W-1:0]  ca,
    input logic signed [AMOUNT_W-1:0] fa,
    input logic signed [COORD_W-1:0]  cb,
    input logic signed [AMOUNT_W-1:0] fb,
    input logic                       neg
  );
    lane_op_t op;
    op.kind    = kind;
    op.coord_a = ca;
    op.fac_a   = fa;
    op.coord_b = cb;
    op.fac_b   = fb;
    op.neg_b   = neg;
    return op;
  endfunction

  // Trig factors are widened to the common factor width.
  assign cos_ext = {{(AMOUNT_W-TRIG_W){cos_val[TRIG_W-1]}}, cos_val};
  assign sin_ext = {{(AMOUNT_W-TRIG_W){sin_val[TRIG_W-1]}}, sin_val};

  // Mode decode: every lane defaults to pass-through.
  always_comb begin
    op_x_nxt = make_op(LANE_PASS, coord_x, '0, '0, '0, 1'b0);
    op_y_nxt = make_op(LANE_PASS, coord_y, '0, '0, '0, 1'b0);
    op_z_nxt = make_op(LANE_PASS, coord_z, '0, '0, '0, 1'b0);
    case (mode)
      MODE_SCALE: begin
        op_x_nxt = make_op(LANE_MAC, coord_x, amount, '0, '0, 1'b0);
        op_y_nxt = make_op(LANE_MAC, coord_y, amount, '0, '0, 1'b0);
        op_z_nxt = make_op(LANE_MAC, coord_z, amount, '0, '0, 1'b0);
      end
      MODE_MOVE_X: op_x_nxt = make_op(LANE_ADD, coord_x, amount, '0, '0, 1'b0);
      MODE_MOVE_Y: op_y_nxt = make_op(LANE_ADD, coord_y, amount, '0, '0, 1'b0);
      MODE_MOVE_Z: op_z_nxt = make_op(LANE_ADD, coord_z, amount, '0, '0, 1'b0);
      MODE_ROT_X: begin
        op_y_nxt = make_op(LANE_MAC, coord_y, cos_ext, coord_z, sin_ext, 1'b1);
        op_z_nxt = make_op(LANE_MAC, coord_y, sin_ext, coord_z, cos_ext, 1'b0);
      end
      MODE_ROT_Y: begin
        op_x_nxt = make_op(LANE_MAC, coord_x, cos_ext, coord_z, sin_ext, 1'b0);
        op_z_nxt = make_op(LANE_MAC, coord_z, cos_ext, coord_x, sin_ext, 1'b1);
      end
      MODE_ROT_Z: begin
        op_x_nxt = make_op(LANE_MAC, coord_x, cos_ext, coord_y, sin_ext, 1'b1);
        op_y_nxt = make_op(LANE_MAC, coord_x, sin_ext, coord_y, cos_ext, 1'b0);
      end
      default: begin
      end
    endcase
  end

  // Operand registers advance with the first stage.
  always_ff @(posedge clk) begin
    if (load) begin
      op_x_r <= op_x_nxt;
      op_y_r <= op_y_nxt;
      op_z_r <= op_z_nxt;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/vat_lane.sv
// One coordinate lane: multiply stage, accumulate stage, round and saturate stage.
// Depends on vat_pkg.
`default_nettype none

module vat_lane (
  input  wire logic                              clk,
  input  wire vat_pkg::pipe_ctrl_t               ctrl,
  input  wire vat_pkg::lane_op_t                 op,
  output logic signed [vat_pkg::COORD_W-1:0]     result_r
);
  import vat_pkg::*;

  localparam int Q_W = ACC_W - FRAC_BITS;
  localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (FRAC_BITS - 1);
  localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  logic signed [PROD_W-1:0]  p0_r;
  logic signed [PROD_W-1:0]  p1_r;
  logic signed [LIN_W-1:0]   lin2_r;
  logic signed [LIN_W-1:0]   lin_nxt;
  lane_kind_t                kind2_r;
  logic                      neg2_r;

  logic signed [ACC_W-1:0]   p0_ext;
  logic signed [ACC_W-1:0]   p1_ext;
  logic signed [ACC_W-1:0]   acc_nxt;
  logic signed [ACC_W-1:0]   acc_r;
  logic signed [LIN_W-1:0]   lin3_r;
  lane_kind_t                kind3_r;

  logic [Q_W-1:0]            q;
  logic [COORD_W-1:0]        mac_sat;
  logic [COORD_W-1:0]        lin_sat;
  logic [COORD_W-1:0]        result_nxt;

  // Stage 2: two signed products and the linear (add or pass) value.
  assign lin_nxt = (op.kind == LANE_ADD)
                 ? ({op.coord_a[COORD_W-1], op.coord_a} + {op.fac_a[AMOUNT_W-1], op.fac_a})
                 : {op.coord_a[COORD_W-1], op.coord_a};

  always_ff @(posedge clk) begin
    if (ctrl.load[1]) begin
      p0_r    <= PROD_W'(op.coord_a) * PROD_W'(op.fac_a);
      p1_r    <= PROD_W'(op.coord_b) * PROD_W'(op.fac_b);
      lin2_r  <= lin_nxt;
      kind2_r <= op.kind;
      neg2_r  <= op.neg_b;
    end
  end

  // Stage 3: exact sum or difference of the products plus the rounding half.
  assign p0_ext  = {{(ACC_W-PROD_W){p0_r[PROD_W-1]}}, p0_r};
  assign p1_ext  = {{(ACC_W-PROD_W){p1_r[PROD_W-1]}}, p1_r};
  assign acc_nxt = neg2_r ? (p0_ext - p1_ext + ROUND_HALF) : (p0_ext + p1_ext + ROUND_HALF);

  always_ff @(posedge clk) begin
    if (ctrl.load[2]) begin
      acc_r   <= acc_nxt;
      lin3_r  <= lin2_r;
      kind3_r <= kind2_r;
    end
  end

  // Stage 4: drop the fraction (floor) and saturate to the coordinate range.
  assign q = acc_r[ACC_W-1:FRAC_BITS];

  always_comb begin
    if ((&q[Q_W-1:COORD_W-1]) || !(|q[Q_W-1:COORD_W-1])) begin
      mac_sat = q[COORD_W-1:0];
    end else begin
      mac_sat = q[Q_W-1] ? COORD_MIN : COORD_MAX;
    end
    if (lin3_r[LIN_W-1] == lin3_r[COORD_W-1]) begin
      lin_sat = lin3_r[COORD_W-1:0];
    end else begin
      lin_sat = lin3_r[LIN_W-1] ? COORD_MIN : COORD_MAX;
    end
    result_nxt = (kind3_r == LANE_MAC) ? mac_sat : lin_sat;
  end

  always_ff @(posedge clk) begin
    if (ctrl.load[3]) begin
      result_r <= result_nxt;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/vat_flow_ctrl.sv
// Valid bits and per-stage load enables for the four-stage pipeline; carries the last flag.
// Depends on vat_pkg.
`default_nettype none

module vat_flow_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  input  wire logic          in_last,
  input  wire logic          out_stall,
  output logic               in_stall,
  output logic               out_valid,
  output logic               out_last,
  output vat_pkg::pipe_ctrl_t ctrl
);
  import vat_pkg::*;

  logic [NUM_STAGES-1:0] valid_r;
  logic [NUM_STAGES-1:0] last_r;
  logic [NUM_STAGES-1:0] load;
  logic                  in_acc;
  logic                  out_acc;

  // A stage loads when it is empty or its contents move on; bubbles collapse.
  always_comb begin
    load[NUM_STAGES-1] = !valid_r[NUM_STAGES-1] || !out_stall;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      load[k] = !valid_r[k] || load[k+1];
    end
  end

  assign ctrl.load = load;
  assign in_stall  = !load[0];
  assign out_valid = valid_r[NUM_STAGES-1];
  assign out_last  = last_r[NUM_STAGES-1];
  assign in_acc    = in_valid && !in_stall;
  assign out_acc   = out_valid && !out_stall;

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      if (load[0]) begin
        valid_r[0] <= in_valid;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (load[k]) begin
          valid_r[k] <= valid_r[k-1];
        end
      end
    end
  end

  // The last-vertex flag rides alongside as payload.
  always_ff @(posedge clk) begin
    if (load[0]) begin
      last_r[0] <= in_last;
    end
    for (int k = 1; k < NUM_STAGES; k++) begin
      if (load[k]) begin
        last_r[k] <= last_r[k-1];
      end
    end
  end

  // The input is held off only when every stage is occupied.
  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (&valid_r))
    else $error("input stalled while a pipeline stage is empty");

  // Items in flight change only by transfers on the two channels.
  a_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> ($countones(valid_r) ==
              $past($countones(valid_r)) + $past(in_acc) - $past(out_acc)))
    else $error("pipeline occupancy does not match channel transfers");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (valid_r == '0))
    else $error("pipeline not empty after reset");

endmodule

`default_nettype wire

// File: hw/rtl/vertex_affine_transform.sv
// Vertex affine transform: scale, translate or rotate a stream of Q16.16 vertices.
// Depends on vat_pkg, vat_operand_sel, vat_lane and vat_flow_ctrl.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one vertex per transfer:
//   in_coord_x/y/z in signed Q16.16 and the in_last_vertex marker.
//   Result channel (out_valid / out_stall) carries one transformed vertex per
//   input, in input order, with out_last_out copied from the marker.
//   The configuration port writes mode, amount, cosine and sine by index
//   (0 to 3) when cfg_we is high; other indexes are ignored. Write it only
//   while no vertex is in flight.
// Pipeline:
//   Four register stages (operand select, multiply, accumulate, round and
//   saturate); each vertex passes through them in that order and its result
//   is held on the output register of the last stage. One vertex per cycle is
//   sustained while the receiver does not stall; each lane has two 32x32
//   multipliers in the multiply stage.
// Reset and back-pressure:
//   Synchronous reset empties the pipeline and restores mode 0 (scale),
//   amount 0, cosine 1.0 and sine 0. When the receiver stalls, the result
//   holds on the output and empty stages behind it keep filling; in_stall
//   rises only once all four stages hold a vertex.
`default_nettype none

module vertex_affine_transform (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  // Configuration write port.
  input  wire logic                                 cfg_we,
  input  wire logic [vat_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  wire logic [vat_pkg::CFG_DATA_W-1:0]        cfg_data,
  // Input channel.
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic signed [vat_pkg::COORD_W-1:0]    in_coord_x,
  input  wire logic signed [vat_pkg::COORD_W-1:0]    in_coord_y,
  input  wire logic signed [vat_pkg::COORD_W-1:0]    in_coord_z,
  input  wire logic                                 in_last_vertex,
  // Result channel.
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic signed [vat_pkg::COORD_W-1:0]         out_new_x,
  output logic signed [vat_pkg::COORD_W-1:0]         out_new_y,
  output logic signed [vat_pkg::COORD_W-1:0]         out_new_z,
  output logic                                      out_last_out
);
  import vat_pkg::*;

  mode_t                       mode_r;
  logic signed [AMOUNT_W-1:0]  amount_r;
  logic signed [TRIG_W-1:0]    cos_r;
  logic signed [TRIG_W-1:0]    sin_r;
  pipe_ctrl_t                  ctrl;
  lane_op_t                    op_x;
  lane_op_t                    op_y;
  lane_op_t                    op_z;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_SCALE;
      amount_r <= AMOUNT_RESET;
      cos_r    <= COS_RESET;
      sin_r    <= SIN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MODE:   mode_r   <= mode_t'(cfg_data[MODE_W-1:0]);
        REG_AMOUNT: amount_r <= cfg_data[AMOUNT_W-1:0];
        REG_COS:    cos_r    <= cfg_data[TRIG_W-1:0];
        REG_SIN:    sin_r    <= cfg_data[TRIG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Handshake and stage enables.
  vat_flow_ctrl u_flow (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_last   (in_last_vertex),
    .out_stall (out_stall),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_last  (out_last_out),
    .ctrl      (ctrl)
  );

  // Stage 1: per-lane operands from the mode.
  vat_operand_sel u_opsel (
    .clk     (clk),
    .load    (ctrl.load[0]),
    .mode    (mode_r),
    .amount  (amount_r),
    .cos_val (cos_r),
    .sin_val (sin_r),
    .coord_x (in_coord_x),
    .coord_y (in_coord_y),
    .coord_z (in_coord_z),
    .op_x_r  (op_x),
    .op_y_r  (op_y),
    .op_z_r  (op_z)
  );

  // Stages 2 to 4: one lane per output coordinate.
  vat_lane u_lane_x (
    .clk      (clk),
    .ctrl     (ctrl),
    .op       (op_x),
    .result_r (out_new_x)
  );

  vat_lane u_lane_y (
    .clk      (clk),
    .ctrl     (ctrl),
    .op       (op_y),
    .result_r (out_new_y)
  );

  vat_lane u_lane_z (
    .clk      (clk),
    .ctrl     (ctrl),
    .op       (op_z),
    .result_r (out_new_z)
  );

endmodule

`default_nettype wire

// File: test/tb_vertex_affine_transform.sv
// Self-checking testbench for vertex_affine_transform: directed and random vertex streams
// under every mode, checked field by field against a behavioral transform predictor.
// Depends on vat_pkg and the vertex_affine_transform RTL.
`default_nettype none

module tb_vertex_affine_transform;
  timeunit 1ns;
  timeprecision 1ps;

  import vat_pkg::*;

  localparam logic signed [COORD_W-1:0] COORD_MAX   = 32'sh7FFF_FFFF;
  localparam logic signed [COORD_W-1:0] COORD_MIN   = 32'sh8000_0000;
  localparam logic signed [COORD_W-1:0] ONE_Q16     = 32'sh0001_0000;
  localparam logic signed [COORD_W-1:0] HALF_Q16    = 32'sh0000_8000;
  localparam int                        TRIG_MAX    = 131071;
  localparam int                        TRIG_MIN    = -131072;
  localparam logic [MODE_W-1:0]         MODE_UNUSED = 3'd7;
  localparam int                        TOP_REG_IDX = 2**CFG_IDX_W - 1;
  localparam int                        RANDOM_ITEMS = 1750;

  typedef struct {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic                      last_flag;
  } vertex_t;

  logic                             clk            = 1'b0;
  logic                             rst_n          = 1'b0;
  logic                             cfg_we         = 1'b0;
  logic [CFG_IDX_W-1:0]             cfg_index      = '0;
  logic [CFG_DATA_W-1:0]            cfg_data       = '0;
  logic                             in_valid       = 1'b0;
  logic                             in_stall;
  logic signed [COORD_W-1:0]        in_coord_x     = '0;
  logic signed [COORD_W-1:0]        in_coord_y     = '0;
  logic signed [COORD_W-1:0]        in_coord_z     = '0;
  logic                             in_last_vertex = 1'b0;
  logic                             out_valid;
  logic                             out_stall      = 1'b0;
  logic signed [COORD_W-1:0]        out_new_x;
  logic signed [COORD_W-1:0]        out_new_y;
  logic signed [COORD_W-1:0]        out_new_z;
  logic                             out_last_out;

  // Register copies that the predictor works from.
  logic [MODE_W-1:0]                model_mode   = MODE_SCALE;
  logic signed [AMOUNT_W-1:0]       model_amount = AMOUNT_RESET;
  logic signed [TRIG_W-1:0]         model_cos    = COS_RESET;
  logic signed [TRIG_W-1:0]         model_sin    = SIN_RESET;

  vertex_t pending_vertices[$];
  vertex_t predicted_vertices[$];
  vertex_t drive_vertex;
  vertex_t seen_vertex;
  vertex_t want_vertex;
  int      send_wait  = 0;
  int      hold_wait  = 0;
  int      send_idle  = 2;
  int      recv_idle  = 2;
  int      fail_count = 0;

  vertex_affine_transform DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_coord_x     (in_coord_x),
    .in_coord_y     (in_coord_y),
    .in_coord_z     (in_coord_z),
    .in_last_vertex (in_last_vertex),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_new_x      (out_new_x),
    .out_new_y      (out_new_y),
    .out_new_z      (out_new_z),
    .out_last_out   (out_last_out)
  );

  always #4 clk = ~clk;

  // Clamp a wide value to the signed Q16.16 coordinate range.
  function automatic logic signed [COORD_W-1:0] clamp_coord(longint v);
    if (v > longint'(COORD_MAX)) return COORD_MAX;
    if (v < longint'(COORD_MIN)) return COORD_MIN;
    return v[COORD_W-1:0];
  endfunction

  // Round a value with 32 fraction bits to nearest (ties upward), then clamp.
  function automatic logic signed [COORD_W-1:0] round_clamp(longint p);
    return clamp_coord((p + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS);
  endfunction

  // Expected transformed vertex under the current register settings.
  function automatic vertex_t transform_vertex(vertex_t v);
    longint  xi;
    longint  yi;
    longint  zi;
    longint  ai;
    longint  ci;
    longint  si;
    vertex_t r;
    xi = v.x;
    yi = v.y;
    zi = v.z;
    ai = model_amount;
    ci = model_cos;
    si = model_sin;
    r  = v;
    case (model_mode)
      MODE_SCALE: begin
        r.x = round_clamp(xi * ai);
        r.y = round_clamp(yi * ai);
        r.z = round_clamp(zi * ai);
      end
      MODE_MOVE_X: r.x = clamp_coord(xi + ai);
      MODE_MOVE_Y: r.y = clamp_coord(yi + ai);
      MODE_MOVE_Z: r.z = clamp_coord(zi + ai);
      MODE_ROT_X: begin
        r.y = round_clamp(ci * yi - si * zi);
        r.z = round_clamp(si * yi + ci * zi);
      end
      MODE_ROT_Y: begin
        r.x = round_clamp(ci * xi + si * zi);
        r.z = round_clamp(ci * zi - si * xi);
      end
      MODE_ROT_Z: begin
        r.x = round_clamp(ci * xi - si * yi);
        r.y = round_clamp(si * xi + ci * yi);
      end
      default: ;
    endcase
    return r;
  endfunction

  // Number of idle cycles before the next transfer on one side.
  function automatic int draw_wait(int level);
    case (level)
      0:       return 0;
      1:       return ($urandom_range(0, 4) == 0) ? int'($urandom_range(1, 11)) : 0;
      default: return $urandom_range(0, 11);
    endcase
  endfunction

  function automatic void check_field(string name, logic signed [COORD_W-1:0] want,
                                      logic signed [COORD_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // Mostly modest coordinates, with full-range values and the extremes mixed in.
  function automatic logic signed [COORD_W-1:0] pick_coord();
    case ($urandom_range(0, 9))
      0:       return COORD_MAX;
      1:       return COORD_MIN;
      2, 3, 4: return $urandom;
      default: return int'($urandom_range(0, 16777216)) - 8388608;
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_amount();
    case ($urandom_range(0, 7))
      0:       return COORD_MAX;
      1:       return COORD_MIN;
      2:       return ONE_Q16;
      3:       return -ONE_Q16;
      4, 5:    return $urandom;
      default: return int'($urandom_range(0, 524288)) - 262144;
    endcase
  endfunction

  // Cosine and sine of a random angle, sometimes raw random words or the 18-bit extremes instead.
  task automatic pick_trig(output logic [CFG_DATA_W-1:0] c, output logic [CFG_DATA_W-1:0] s);
    real angle;
    angle = $urandom_range(0, 3599) * 3.14159265358979 / 1800.0;
    case ($urandom_range(0, 5))
      0: begin
        c = $urandom;
        s = $urandom;
      end
      1: begin
        c = ($urandom_range(0, 1) != 0) ? TRIG_MAX : TRIG_MIN;
        s = ($urandom_range(0, 1) != 0) ? TRIG_MAX : TRIG_MIN;
      end
      default: begin
        c = int'($cos(angle) * 65536.0);
        s = int'($sin(angle) * 65536.0);
      end
    endcase
  endtask

  // One register write; the predictor's copy follows the same decode.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      REG_MODE:   model_mode   = data[MODE_W-1:0];
      REG_AMOUNT: model_amount = data;
      REG_COS:    model_cos    = data[TRIG_W-1:0];
      REG_SIN:    model_sin    = data[TRIG_W-1:0];
      default: ;
    endcase
  endtask

  // Mode write with the unused data bits randomized.
  task automatic write_mode(logic [MODE_W-1:0] mode);
    write_reg(REG_MODE, ($urandom & ~32'h7) | 32'(mode));
  endtask

  task automatic configure(logic [MODE_W-1:0] mode, logic [CFG_DATA_W-1:0] amount,
                           logic [CFG_DATA_W-1:0] c, logic [CFG_DATA_W-1:0] s);
    write_mode(mode);
    write_reg(REG_AMOUNT, amount);
    write_reg(REG_COS, c);
    write_reg(REG_SIN, s);
  endtask

  task automatic queue_vertex(logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y,
                              logic signed [COORD_W-1:0] z, logic last_flag);
    vertex_t v;
    v.x         = x;
    v.y         = y;
    v.z         = z;
    v.last_flag = last_flag;
    pending_vertices.push_back(v);
  endtask

  // Block until every queued vertex has gone in and every result has come back.
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_vertices.size() != 0 || in_valid || predicted_vertices.size() != 0);
  endtask

  // Input driver: pops queued vertices and holds each one until its transfer.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid  <= 1'b0;
      send_wait = 0;
    end else if (!in_valid || !in_stall) begin
      if (send_wait > 0) begin
        send_wait--;
        in_valid <= 1'b0;
      end else if (pending_vertices.size() != 0) begin
        drive_vertex   = pending_vertices.pop_front();
        in_coord_x     <= drive_vertex.x;
        in_coord_y     <= drive_vertex.y;
        in_coord_z     <= drive_vertex.z;
        in_last_vertex <= drive_vertex.last_flag;
        in_valid       <= 1'b1;
        send_wait      = draw_wait(send_idle);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: predicts on each input transfer, checks each result transfer,
  // and drives the receiver's stall.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_wait = 0;
    end else begin
      if (in_valid && !in_stall) begin
        seen_vertex.x         = in_coord_x;
        seen_vertex.y         = in_coord_y;
        seen_vertex.z         = in_coord_z;
        seen_vertex.last_flag = in_last_vertex;
        predicted_vertices.push_back(transform_vertex(seen_vertex));
      end
      if (out_valid && !out_stall) begin
        if (predicted_vertices.size() == 0) begin
          $error("result transfer with no vertex outstanding");
          fail_count++;
        end else begin
          want_vertex = predicted_vertices.pop_front();
          check_field("new_x", want_vertex.x, out_new_x);
          check_field("new_y", want_vertex.y, out_new_y);
          check_field("new_z", want_vertex.z, out_new_z);
          check_field("last_out", COORD_W'(want_vertex.last_flag), COORD_W'(out_last_out));
        end
        hold_wait = draw_wait(recv_idle);
      end else if (hold_wait > 0) begin
        hold_wait--;
      end
      out_stall <= (hold_wait > 0);
    end
  end

  // Stimulus: directed corner cases, then random phases with fresh settings.
  initial begin
    int random_sent;
    int n;
    logic [CFG_DATA_W-1:0] c;
    logic [CFG_DATA_W-1:0] s;
    random_sent = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: scale by zero.
    queue_vertex(COORD_MAX, COORD_MIN, 1, 1'b1);
    wait_drained();

    // Scale by one half: rounding ties go upward.
    configure(MODE_SCALE, HALF_Q16, ONE_Q16, 0);
    queue_vertex(1, -1, 3, 1'b0);
    queue_vertex(COORD_MIN, COORD_MAX, -3, 1'b1);
    wait_drained();

    // Scale by the most negative amount: saturation both ways.
    configure(MODE_SCALE, COORD_MIN, ONE_Q16, 0);
    queue_vertex(COORD_MAX, COORD_MIN, ONE_Q16, 1'b0);
    wait_drained();

    // Translations that overflow.
    configure(MODE_MOVE_X, COORD_MAX, ONE_Q16, 0);
    queue_vertex(COORD_MAX, 5, 6, 1'b0);
    queue_vertex(COORD_MIN, COORD_MAX, COORD_MIN, 1'b1);
    wait_drained();
    configure(MODE_MOVE_Y, COORD_MIN, ONE_Q16, 0);
    queue_vertex(1, COORD_MIN, 3, 1'b1);
    wait_drained();
    configure(MODE_MOVE_Z, -1, ONE_Q16, 0);
    queue_vertex(7, 8, COORD_MIN, 1'b0);
    wait_drained();

    // Rotations, including trig values beyond one.
    configure(MODE_ROT_X, 0, TRIG_MIN, TRIG_MAX);
    queue_vertex(1, COORD_MAX, COORD_MIN, 1'b0);
    queue_vertex(0, COORD_MIN, COORD_MIN, 1'b1);
    wait_drained();
    configure(MODE_ROT_Y, 0, ONE_Q16, -ONE_Q16);
    queue_vertex(COORD_MAX, 0, COORD_MAX, 1'b0);
    queue_vertex(COORD_MIN, 3, COORD_MIN, 1'b1);
    wait_drained();
    configure(MODE_ROT_Z, 0, -ONE_Q16, ONE_Q16);
    queue_vertex(COORD_MAX, COORD_MIN, 9, 1'b0);
    queue_vertex(HALF_Q16, -HALF_Q16, 2, 1'b1);
    wait_drained();
    configure(MODE_ROT_Z, 0, 46341, 46341);
    queue_vertex(3, -5, 0, 1'b1);
    wait_drained();

    // The unused mode passes vertices through; writes to unused indexes are dropped.
    configure(MODE_UNUSED, ONE_Q16, TRIG_MIN, TRIG_MIN);
    for (int idx = REG_SIN + 1; idx <= TOP_REG_IDX; idx++)
      write_reg(CFG_IDX_W'(idx), $urandom);
    queue_vertex(COORD_MAX, COORD_MIN, -1, 1'b1);
    wait_drained();

    // Random phases, each with its own settings and idle pattern.
    while (random_sent < RANDOM_ITEMS) begin
      send_idle = $urandom_range(0, 2);
      recv_idle = $urandom_range(0, 2);
      write_mode(MODE_W'($urandom_range(0, 7)));
      if ($urandom_range(0, 1) != 0)
        write_reg(REG_AMOUNT, pick_amount());
      if ($urandom_range(0, 1) != 0) begin
        pick_trig(c, s);
        write_reg(REG_COS, c);
        write_reg(REG_SIN, s);
      end
      if ($urandom_range(0, 3) == 0)
        write_reg(CFG_IDX_W'($urandom_range(REG_SIN + 1, TOP_REG_IDX)), $urandom);
      n = $urandom_range(10, 80);
      for (int i = 0; i < n; i++)
        queue_vertex(pick_coord(), pick_coord(), pick_coord(),
                     (i == n - 1) || ($urandom_range(0, 15) == 0));
      random_sent += n;
      wait_drained();
    end

    // Give any stray result time to show up.
    repeat (2 * NUM_STAGES + 4) @(posedge clk);
    if (fail_count == 0)
      $display("PASS vertex_affine_transform");
    else
      $display("FAIL vertex_affine_transform");
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #5_000_000;
    $display("FAIL vertex_affine_transform");
    $finish;
  end

endmodule

`default_nettype wire
